// ----- hdl/wkt_lex_pkg.sv -----
// shared types, keyword table and character codes for the wkt text lexer
`timescale 1ns / 1ps

package wkt_lex_pkg;

  localparam int unsigned MaxKeywordLenDef = 10;
  localparam int unsigned LineCountBitsDef = 16;

  localparam int unsigned NumKeywords = 24;
  localparam int unsigned KwChars     = 12;
  localparam int unsigned QueueDepth  = 4;

  typedef enum logic [3:0] {
    KIND_LBRK    = 4'd0,
    KIND_RBRK    = 4'd1,
    KIND_COMMA   = 4'd2,
    KIND_KEYWORD = 4'd3,
    KIND_NUMEND  = 4'd4,
    KIND_STREND  = 4'd5,
    KIND_EOI     = 4'd6,
    KIND_ERROR   = 4'd7,
    KIND_BYTE    = 4'd8
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [4:0]  kw;
    logic [7:0]  text;
    logic [15:0] line;
    logic        last;
  } rslt_t;

  // character codes
  localparam logic [7:0] ChLbrk  = 8'h5B;
  localparam logic [7:0] ChRbrk  = 8'h5D;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChUnder = 8'h5F;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChUpE   = 8'h45;
  localparam logic [7:0] ChLowE  = 8'h65;
  localparam logic [7:0] CaseBit = 8'h20;

  // keyword text, right-justified, first character in the highest used byte
  localparam logic [KwChars*8-1:0] KW_TEXT [NumKeywords] = '{
    (KwChars*8)'({"COMPD_", "CS"}), (KwChars*8)'("PROJCS"),
    (KwChars*8)'("PROJECTION"),     (KwChars*8)'("PARAMETER"),
    (KwChars*8)'("GEOGCS"),         (KwChars*8)'("DATUM"),
    (KwChars*8)'("SPHEROID"),       (KwChars*8)'("PRIMEM"),
    (KwChars*8)'("UNIT"),           (KwChars*8)'("AUTHORITY"),
    (KwChars*8)'("AXIS"),           (KwChars*8)'("TOWGS84"),
    (KwChars*8)'("NORTH"),          (KwChars*8)'("SOUTH"),
    (KwChars*8)'("EAST"),           (KwChars*8)'("WEST"),
    (KwChars*8)'("UP"),             (KwChars*8)'("DOWN"),
    (KwChars*8)'("OTHER"),          (KwChars*8)'("VERT_CS"),
    (KwChars*8)'({"VERT_", "DATUM"}), (KwChars*8)'("GEOCCS"),
    (KwChars*8)'({"FITTED_", "CS"}), (KwChars*8)'({"LOCAL_", "CS"})
  };

  localparam logic [3:0] KW_LEN [NumKeywords] = '{
    4'd8, 4'd6, 4'd10, 4'd9, 4'd6, 4'd5, 4'd8, 4'd6, 4'd4, 4'd9, 4'd4, 4'd7,
    4'd5, 4'd5, 4'd4, 4'd4, 4'd2, 4'd4, 4'd5, 4'd7, 4'd10, 4'd6, 4'd9, 4'd8
  };

  // character of keyword k at position pos, zero past its end
  function automatic logic [7:0] kw_char(input logic [4:0] k, input logic [3:0] pos);
    logic [KwChars*8-1:0] w;
    logic [3:0]           l;
    logic [3:0]           sh;
    logic [7:0]           ch;
    w  = KW_TEXT[k];
    l  = KW_LEN[k];
    sh = l - 4'd1 - pos;
    ch = 8'h00;
    if (pos < l) begin
      ch = w[8*sh +: 8];
    end
    return ch;
  endfunction

endpackage

// ----- hdl/wkt_projection_text_lexer.sv -----
// streaming tokenizer for well-known-text coordinate-system text
// output: an item's results are registered in the result queue and leave its head in order
// throughput: one item per cycle while items give at most one result; an item with two
//   results fills two queue entries, and input stalls when the four-entry
//   result queue has fewer than two free slots
// reset: scan state idle, line count one, error flag clear, result queue empty
`timescale 1ns / 1ps

module wkt_projection_text_lexer
  import wkt_lex_pkg::*;
#(
  parameter int unsigned MAX_KEYWORD_LEN = MaxKeywordLenDef,
  parameter int unsigned LINE_COUNT_BITS = LineCountBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_byte_i,
  input  logic        end_of_input_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  result_kind_o,
  output logic [4:0]  keyword_index_o,
  output logic [7:0]  text_byte_o,
  output logic [15:0] line_number_o,
  output logic        last_of_run_o
);

  localparam int unsigned LenW = $clog2(MAX_KEYWORD_LEN + 1);
  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  localparam logic [2:0] M_IDLE    = 3'd0;
  localparam logic [2:0] M_IDENT   = 3'd1;
  localparam logic [2:0] M_INT     = 3'd2;
  localparam logic [2:0] M_FRAC    = 3'd3;
  localparam logic [2:0] M_EXPMARK = 3'd4;
  localparam logic [2:0] M_EXPDIG  = 3'd5;
  localparam logic [2:0] M_STRING  = 3'd6;

  logic [2:0]                 mode_q, mode_d;
  logic [NumKeywords-1:0]     cand_q, cand_d;
  logic [LenW-1:0]            len_q, len_d;
  logic [LINE_COUNT_BITS-1:0] line_q, line_d;
  logic                       fail_q, fail_d;

  rslt_t           queue_q [QueueDepth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [CntW-1:0] cnt_q;

  logic in_xfer, out_xfer;
  assign in_xfer  = in_valid_i & in_ready_o;
  assign out_xfer = out_valid_o & out_ready_i;

  // character classes
  logic [7:0] c, up;
  logic       eoi, is_digit, is_alpha, is_space, is_ident, is_e, is_sign;
  assign c        = char_byte_i;
  assign eoi      = end_of_input_i;
  assign is_digit = (c >= "0") && (c <= "9");
  assign is_alpha = ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
  assign is_space = (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  assign is_ident = is_alpha || is_digit || (c == ChUnder);
  assign is_e     = (c == ChUpE) || (c == ChLowE);
  assign is_sign  = (c == ChPlus) || (c == ChMinus);
  assign up       = ((c >= "a") && (c <= "z")) ? (c - CaseBit) : c;

  // keyword match at the end of an identifier: lowest matching entry wins
  logic       kw_hit;
  logic [4:0] kw_idx;
  always_comb begin
    kw_hit = 1'b0;
    kw_idx = '0;
    for (int k = NumKeywords - 1; k >= 0; k--) begin
      if (cand_q[k] && ({{(8-LenW){1'b0}}, len_q} == {4'd0, KW_LEN[k]})) begin
        kw_hit = 1'b1;
        kw_idx = 5'(k);
      end
    end
  end

  // candidate narrowing for one identifier character
  logic [NumKeywords-1:0] base_cand, step_cand;
  logic [LenW-1:0]        base_len, step_len;
  always_comb begin
    base_cand = (mode_q == M_IDENT) ? cand_q : '1;
    base_len  = (mode_q == M_IDENT) ? len_q : '0;
    step_len  = base_len;
    step_cand = '0;
    if ({{(8-LenW){1'b0}}, base_len} < 8'(MAX_KEYWORD_LEN)) begin
      step_len = base_len + 1'b1;
      for (int k = 0; k < NumKeywords; k++) begin
        step_cand[k] = base_cand[k] && (kw_char(5'(k), 4'(base_len)) == up);
      end
    end
  end

  // handling of a byte between tokens
  logic       idl_emit, idl_fail, idl_ident, idl_nl;
  kind_e      idl_kind;
  logic [7:0] idl_byte;
  logic [2:0] idl_mode;
  always_comb begin
    idl_emit  = 1'b0;
    idl_fail  = 1'b0;
    idl_ident = 1'b0;
    idl_nl    = 1'b0;
    idl_kind  = KIND_ERROR;
    idl_byte  = '0;
    idl_mode  = M_IDLE;
    if (eoi) begin
      idl_emit = 1'b1;
      idl_kind = KIND_EOI;
    end else if (is_space) begin
      idl_nl = (c == ChLf);
    end else if (c == ChLbrk) begin
      idl_emit = 1'b1;
      idl_kind = KIND_LBRK;
    end else if (c == ChRbrk) begin
      idl_emit = 1'b1;
      idl_kind = KIND_RBRK;
    end else if (c == ChComma) begin
      idl_emit = 1'b1;
      idl_kind = KIND_COMMA;
    end else if (is_alpha) begin
      idl_ident = 1'b1;
      idl_mode  = M_IDENT;
    end else if (is_digit || is_sign) begin
      idl_emit = 1'b1;
      idl_kind = KIND_BYTE;
      idl_byte = c;
      idl_mode = M_INT;
    end else if (c == ChDot) begin
      idl_emit = 1'b1;
      idl_kind = KIND_BYTE;
      idl_byte = c;
      idl_mode = M_FRAC;
    end else if (c == ChQuote) begin
      idl_mode = M_STRING;
    end else begin
      idl_emit = 1'b1;
      idl_fail = 1'b1;
    end
  end

  // per-item step: a = token end result, b = result of the byte itself
  logic       a_v, b_v, use_idle, id_do;
  kind_e      a_kind, b_kind;
  logic [4:0] a_kw;
  logic [7:0] b_byte;
  always_comb begin
    a_v      = 1'b0;
    a_kind   = KIND_NUMEND;
    a_kw     = '0;
    b_v      = 1'b0;
    b_kind   = KIND_ERROR;
    b_byte   = '0;
    use_idle = 1'b0;
    id_do    = 1'b0;
    mode_d   = mode_q;
    fail_d   = fail_q;
    if (fail_q) begin
      b_v = 1'b1;
    end else begin
      unique case (mode_q) inside
        M_IDENT: begin
          if (!eoi && is_ident) begin
            id_do = 1'b1;
          end else if (kw_hit) begin
            a_v      = 1'b1;
            a_kind   = KIND_KEYWORD;
            a_kw     = kw_idx;
            use_idle = 1'b1;
          end else begin
            b_v    = 1'b1;
            fail_d = 1'b1;
            mode_d = M_IDLE;
          end
        end
        M_INT, M_FRAC, M_EXPDIG: begin
          if (!eoi && is_digit) begin
            b_v    = 1'b1;
            b_kind = KIND_BYTE;
            b_byte = c;
          end else if (!eoi && (mode_q == M_INT) && (c == ChDot)) begin
            b_v    = 1'b1;
            b_kind = KIND_BYTE;
            b_byte = c;
            mode_d = M_FRAC;
          end else if (!eoi && (mode_q != M_EXPDIG) && is_e) begin
            b_v    = 1'b1;
            b_kind = KIND_BYTE;
            b_byte = c;
            mode_d = M_EXPMARK;
          end else begin
            a_v      = 1'b1;
            a_kind   = KIND_NUMEND;
            use_idle = 1'b1;
          end
        end
        M_EXPMARK: begin
          b_v = 1'b1;
          if (!eoi && (is_sign || is_digit)) begin
            b_kind = KIND_BYTE;
            b_byte = c;
            mode_d = M_EXPDIG;
          end else begin
            fail_d = 1'b1;
            mode_d = M_IDLE;
          end
        end
        M_STRING: begin
          b_v = 1'b1;
          if (eoi) begin
            fail_d = 1'b1;
            mode_d = M_IDLE;
          end else if (c == ChQuote) begin
            b_kind = KIND_STREND;
            mode_d = M_IDLE;
          end else begin
            b_kind = KIND_BYTE;
            b_byte = c;
          end
        end
        default: begin
          use_idle = 1'b1;
        end
      endcase
      if (use_idle) begin
        b_v    = idl_emit;
        b_kind = idl_fail ? KIND_ERROR : idl_kind;
        b_byte = idl_byte;
        mode_d = idl_mode;
        fail_d = idl_fail;
        id_do  = idl_ident;
      end
    end
  end

  // identifier registers and line count
  always_comb begin
    cand_d = cand_q;
    len_d  = len_q;
    line_d = line_q;
    if (id_do) begin
      cand_d = step_cand;
      len_d  = step_len;
    end else if (a_v && (a_kind == KIND_KEYWORD)) begin
      cand_d = '1;
      len_d  = '0;
    end
    if (use_idle && !fail_q && idl_nl && (line_q != '1)) begin
      line_d = line_q + 1'b1;
    end
  end

  // assemble up to two results for the queue
  logic [31:0]     line_ext;
  rslt_t           slot0, slot1;
  logic [1:0]      n_res;
  always_comb begin
    line_ext   = 32'(line_q);
    slot0      = '0;
    slot1      = '0;
    slot0.line = line_ext[15:0];
    slot1.line = line_ext[15:0];
    slot1.kind = b_kind;
    slot1.text = b_byte;
    slot1.last = 1'b1;
    if (a_v) begin
      slot0.kind = a_kind;
      slot0.kw   = a_kw;
      slot0.last = !b_v;
      n_res      = b_v ? 2'd2 : 2'd1;
    end else begin
      slot0      = slot1;
      n_res      = {1'b0, b_v};
    end
  end

  assign in_ready_o = (cnt_q <= CntW'(QueueDepth - 2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      cand_q <= '1;
      len_q  <= '0;
      line_q <= LINE_COUNT_BITS'(1);
      fail_q <= 1'b0;
    end else if (in_xfer) begin
      mode_q <= mode_d;
      cand_q <= cand_d;
      len_q  <= len_d;
      line_q <= line_d;
      fail_q <= fail_d;
    end
  end

  // result queue control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (in_xfer) begin
        wp_q <= wp_q + PtrW'(n_res);
      end
      if (out_xfer) begin
        rp_q <= rp_q + 1'b1;
      end
      cnt_q <= cnt_q + (in_xfer ? CntW'(n_res) : '0) - CntW'(out_xfer);
    end
  end

  // result queue storage
  always_ff @(posedge clk_i) begin
    if (in_xfer && (n_res != 2'd0)) begin
      queue_q[wp_q] <= slot0;
      if (n_res == 2'd2) begin
        queue_q[wp_q + 1'b1] <= slot1;
      end
    end
  end

  rslt_t head;
  assign head            = queue_q[rp_q];
  assign out_valid_o     = (cnt_q != '0);
  assign result_kind_o   = head.kind;
  assign keyword_index_o = head.kw;
  assign text_byte_o     = head.text;
  assign line_number_o   = head.line;
  assign last_of_run_o   = head.last;

`ifndef ASSERT_OFF
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(QueueDepth))
    else $error("result queue overflow");

  a_fail_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fail_q |=> fail_q)
    else $error("error flag cleared without reset");

  a_fail_error_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && fail_q) |-> (n_res == 2'd1 && slot0.kind == KIND_ERROR))
    else $error("failed lexer gave a result other than a single error");

  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q != '0)
    else $error("line count wrapped to zero");
`endif

endmodule
